// ===== rtl/swrf_pkg.sv =====
// Shared types and constants for the sliding-window residue frequency block.
// Used by swrf_cell, swrf_div and sliding_window_residue_frequency_top.
package swrf_pkg;

  localparam int RES_W      = 8;
  localparam int CNT_W      = 11;
  localparam int POS_W      = 32;
  localparam int STEP_W     = 16;
  localparam int FREQ_W     = 17;
  localparam int MASK_W     = 26;
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = CNT_W + FRAC_W;
  localparam int DIV_CNT_W  = 5;
  localparam int SEG_BITS   = 32;
  localparam int SEG_IDX_W  = 5;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int OUT_DATA_W = 64;
  localparam int SETTLE_W   = 2;

  localparam logic [CNT_W-1:0]    COUNT_MAX   = '1;
  localparam logic [POS_W-1:0]    INDEX_MAX   = '1;
  localparam logic [FREQ_W-1:0]   FREQ_MAX    = '1;
  localparam logic [SETTLE_W-1:0] SETTLE_DONE = 2'd2;

  localparam logic [RES_W-1:0] CHAR_LO_A   = 8'h61;
  localparam logic [RES_W-1:0] CHAR_LO_Z   = 8'h7a;
  localparam logic [RES_W-1:0] CHAR_UP_A   = 8'h41;
  localparam logic [RES_W-1:0] CHAR_UP_Z   = 8'h5a;
  localparam logic [RES_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    REG_LETTER_MASK    = 2'd0,
    REG_WINDOW_LENGTH  = 2'd1,
    REG_STEP_LENGTH    = 2'd2,
    REG_FIRST_POSITION = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_OUT,
    ST_NORM
  } state_e;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [STEP_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quo;
    logic [STEP_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                 shift;
    logic [SEG_IDX_W-1:0] sel;
  } cell_ctrl_t;

  // Lowest field last: window_start sits in the low bits.
  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [CNT_W-1:0]  member_count;
    logic [POS_W-1:0]  window_start;
  } result_t;

endpackage

// ===== rtl/swrf_cell.sv =====
// One segment of the membership history line: shifts one bit per residue
// and registers its local tap. Depends on swrf_pkg.
module swrf_cell (
  input  logic                 clk_i,
  input  swrf_pkg::cell_ctrl_t ctrl_i,
  input  logic                 carry_i,
  output logic                 carry_o,
  output logic                 tap_o
);
  import swrf_pkg::*;

  logic [SEG_BITS-1:0] bits_q;
  logic                tap_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      bits_q <= {bits_q[SEG_BITS-2:0], carry_i};
    end
    tap_q <= bits_q[ctrl_i.sel];
  end

  assign carry_o = bits_q[SEG_BITS-1];
  assign tap_o   = tap_q;

endmodule

// ===== rtl/swrf_div.sv =====
// Restoring divider, one quotient bit per cycle, with remainder.
// Depends on swrf_pkg.
module swrf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swrf_pkg::div_req_t req_i,
  output swrf_pkg::div_rsp_t rsp_o
);
  import swrf_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     quo_q;
  logic [STEP_W-1:0]    rem_q;
  logic [STEP_W-1:0]    den_q;
  logic [STEP_W:0]      trial;
  logic [STEP_W:0]      diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(NUM_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/sliding_window_residue_frequency_top.sv =====
// Sliding-window residue frequency: a row of history cells plus a shared divider.
// An input residue is registered and then updates the state; a window result also
// passes through the shared divider and then into the output register.
// A new residue is taken only once the history tap settles over its two registered
// select levels, and after a result only once the output register is free.
// Reset clears counters, registers to defaults; a step write while idle renormalizes the phase.
module sliding_window_residue_frequency_top #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swrf_pkg::RES_W-1:0]      s_axis_tdata,   // [7:0] residue
  input  logic                            s_axis_tlast,   // last_residue
  // stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] window_start, [42:32] member_count, [59:43] frequency, [63:60] zero
  output logic [swrf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swrf_pkg::ADDR_W-1:0]     paddr,
  input  logic [swrf_pkg::DATA_W-1:0]     pwdata,
  output logic [swrf_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import swrf_pkg::*;

  localparam int SEG_CNT    = (MAX_WINDOW + SEG_BITS - 1) / SEG_BITS;
  localparam int CELL_IDX_W = (SEG_CNT > 1) ? $clog2(SEG_CNT) : 1;
  localparam int NUM_CELLS  = 1 << CELL_IDX_W;
  localparam int TAP_W      = SEG_IDX_W + CELL_IDX_W;

  // registers
  logic [MASK_W-1:0] letter_mask_q;
  logic [CNT_W-1:0]  window_length_q;
  logic [STEP_W-1:0] step_length_q;
  logic [POS_W-1:0]  first_position_q;

  logic     cfg_wr;
  logic     cfg_step_wr;
  reg_idx_e cfg_idx;

  assign pready      = 1'b1;
  assign cfg_idx     = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_step_wr = cfg_wr && (cfg_idx == REG_STEP_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_mask_q    <= '0;
      window_length_q  <= CNT_W'(1);
      step_length_q    <= STEP_W'(1);
      first_position_q <= POS_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LETTER_MASK:    letter_mask_q    <= pwdata[MASK_W-1:0];
        REG_WINDOW_LENGTH:  window_length_q  <= pwdata[CNT_W-1:0];
        REG_STEP_LENGTH:    step_length_q    <= pwdata[STEP_W-1:0];
        REG_FIRST_POSITION: first_position_q <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LETTER_MASK:    prdata = DATA_W'(letter_mask_q);
      REG_WINDOW_LENGTH:  prdata = DATA_W'(window_length_q);
      REG_STEP_LENGTH:    prdata = DATA_W'(step_length_q);
      REG_FIRST_POSITION: prdata = first_position_q;
      default:            prdata = '0;
    endcase
  end

  // effective window and step
  logic [CNT_W-1:0]  win_eff;
  logic [CNT_W-1:0]  win_m1;
  logic [STEP_W-1:0] step_eff;
  logic [STEP_W-1:0] step_new;
  logic [TAP_W-1:0]  tap_idx;

  always_comb begin
    if (window_length_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_length_q) > 32'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = window_length_q;
    end
  end

  assign win_m1   = win_eff - CNT_W'(1);
  assign tap_idx  = TAP_W'(win_m1);
  assign step_eff = (step_length_q == '0) ? STEP_W'(1) : step_length_q;
  assign step_new = (pwdata[STEP_W-1:0] == '0) ? STEP_W'(1) : pwdata[STEP_W-1:0];

  // control state
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [POS_W-1:0]     index_q, index_d;
  logic [STEP_W-1:0]    phase_q, phase_d;
  logic [STEP_W-1:0]    phase_raw_q, phase_raw_d;
  logic [SETTLE_W-1:0]  settle_q, settle_d;
  logic                 out_valid_q, out_valid_d;

  // payload
  logic                 member_q, member_d;
  logic                 last_q, last_d;
  logic [POS_W-1:0]     res_start_q, res_start_d;
  logic [CNT_W-1:0]     res_count_q, res_count_d;
  logic [FREQ_W-1:0]    res_freq_q, res_freq_d;
  result_t              out_q;
  logic                 out_load;

  // history line
  cell_ctrl_t           cell_ctrl;
  logic                 shift;
  logic [NUM_CELLS-1:0] cell_tap;
  logic [NUM_CELLS-2:0] carry;
  logic                 old_bit_q;

  assign cell_ctrl.shift = shift;
  assign cell_ctrl.sel   = tap_idx[SEG_IDX_W-1:0];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      swrf_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .carry_i(member_q),
        .carry_o(carry[i]),
        .tap_o  (cell_tap[i])
      );
    end else if (i == NUM_CELLS - 1) begin : g_tail
      swrf_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .carry_i(carry[i-1]),
        .carry_o(),
        .tap_o  (cell_tap[i])
      );
    end else begin : g_body
      swrf_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .carry_i(carry[i-1]),
        .carry_o(carry[i]),
        .tap_o  (cell_tap[i])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    old_bit_q <= cell_tap[tap_idx[TAP_W-1:SEG_IDX_W]];
  end

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  swrf_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // residue classification
  logic [RES_W-1:0] upper;
  logic [4:0]       letter;
  logic             member_in;

  always_comb begin
    upper = s_axis_tdata;
    if (s_axis_tdata >= CHAR_LO_A && s_axis_tdata <= CHAR_LO_Z) begin
      upper = s_axis_tdata - CASE_OFFSET;
    end
    letter    = 5'(upper - CHAR_UP_A);
    member_in = (upper >= CHAR_UP_A && upper <= CHAR_UP_Z) && letter_mask_q[letter];
  end

  // per-residue update
  logic              tap_ok;
  logic              in_acc;
  logic [CNT_W-1:0]  count_dec;
  logic [CNT_W-1:0]  count_inc;
  logic [POS_W-1:0]  index_inc;
  logic              win_full;
  logic [STEP_W:0]   phase_p1;
  logic [FREQ_W-1:0] freq_sat;

  assign tap_ok        = (settle_q == SETTLE_DONE);
  assign s_axis_tready = (state_q == ST_IDLE) && tap_ok && !cfg_wr;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    count_dec = count_q;
    if (index_q >= POS_W'(win_eff) && old_bit_q && count_q != '0) begin
      count_dec = count_q - CNT_W'(1);
    end
    count_inc = count_dec;
    if (member_q && count_dec != COUNT_MAX) begin
      count_inc = count_dec + CNT_W'(1);
    end
    index_inc = (index_q == INDEX_MAX) ? index_q : index_q + POS_W'(1);
    win_full  = index_inc >= POS_W'(win_eff);
    phase_p1  = {1'b0, phase_q} + (STEP_W+1)'(1);
    freq_sat  = (div_rsp.quo > NUM_W'(FREQ_MAX)) ? FREQ_MAX : div_rsp.quo[FREQ_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    index_d     = index_q;
    phase_d     = phase_q;
    phase_raw_d = phase_raw_q;
    member_d    = member_q;
    last_d      = last_q;
    res_start_d = res_start_q;
    res_count_d = res_count_q;
    res_freq_d  = res_freq_q;
    shift       = 1'b0;
    out_load    = 1'b0;
    div_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_step_wr) begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(phase_raw_q);
          div_req.den   = step_new;
          state_d       = ST_NORM;
        end else if (in_acc) begin
          member_d = member_in;
          last_d   = s_axis_tlast;
          state_d  = ST_UPDATE;
        end
      end
      ST_NORM: begin
        // reduce the unreduced phase so repeated step writes do not compound
        if (cfg_step_wr) begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(phase_raw_q);
          div_req.den   = step_new;
        end else if (div_rsp.done) begin
          phase_d = div_rsp.rem;
          state_d = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        shift   = 1'b1;
        count_d = count_inc;
        index_d = index_inc;
        state_d = ST_IDLE;
        if (win_full) begin
          // phase is kept below the step, so the window fires at phase zero
          phase_d     = (phase_p1 == {1'b0, step_eff}) ? '0 : phase_p1[STEP_W-1:0];
          phase_raw_d = phase_d;
          if (phase_q == '0) begin
            res_start_d   = first_position_q + (index_inc - POS_W'(win_eff));
            res_count_d   = count_inc;
            div_req.start = 1'b1;
            div_req.num   = {count_inc, FRAC_W'(0)} + NUM_W'(win_eff >> 1);
            div_req.den   = STEP_W'(win_eff);
            state_d       = ST_DIV;
          end
        end
        if (last_q) begin
          count_d     = '0;
          index_d     = '0;
          phase_d     = '0;
          phase_raw_d = '0;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_freq_d = freq_sat;
          state_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (shift || cfg_wr) begin
      settle_d = '0;
    end else if (settle_q == SETTLE_DONE) begin
      settle_d = settle_q;
    end else begin
      settle_d = settle_q + SETTLE_W'(1);
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      index_q     <= '0;
      phase_q     <= '0;
      phase_raw_q <= '0;
      settle_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      index_q     <= index_d;
      phase_q     <= phase_d;
      phase_raw_q <= phase_raw_d;
      settle_q    <= settle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    member_q    <= member_d;
    last_q      <= last_d;
    res_start_q <= res_start_d;
    res_count_q <= res_count_d;
    res_freq_q  <= res_freq_d;
    if (out_load) begin
      out_q.window_start <= res_start_q;
      out_q.member_count <= res_count_q;
      out_q.frequency    <= res_freq_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);

endmodule
